/* hw/rtl/scasc_pkg.sv */
// Shared constants and the key-to-character lookup for the scan code to ASCII
// line input core. No dependencies.
package scasc_pkg;

    // Line buffer size held by the consumer; one slot stays reserved.
    localparam int LINE_CAPACITY = 256;
    localparam logic [7:0] LINE_LIMIT = 8'(LINE_CAPACITY - 1);

    // Set-1 scan codes with a meaning of their own.
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
    localparam logic [7:0] KEY_TABLE_SIZE  = 8'd58;

    // Control characters the line logic acts on.
    localparam logic [6:0] CHAR_NONE      = 7'h00;
    localparam logic [6:0] CHAR_BACKSPACE = 7'h08;
    localparam logic [6:0] CHAR_NEWLINE   = 7'h0A;

    // Result item, highest field first in the packed tdata.
    typedef struct packed {
        logic       char_dropped;
        logic [7:0] line_length;
        logic [6:0] char_code;
        logic       char_valid;
    } line_event_t;

    // Character for a make code below the table size, plain or shifted.
    function automatic logic [6:0] key_char(input logic [5:0] idx, input logic shift);
        logic [6:0] p;
        logic [6:0] s;
        begin
            p = CHAR_NONE;
            s = CHAR_NONE;
            case (idx)
                6'd1:  begin p = 7'h1B; s = 7'h1B; end
                6'd2:  begin p = 7'h31; s = 7'h21; end
                6'd3:  begin p = 7'h32; s = 7'h40; end
                6'd4:  begin p = 7'h33; s = 7'h23; end
                6'd5:  begin p = 7'h34; s = 7'h24; end
                6'd6:  begin p = 7'h35; s = 7'h25; end
                6'd7:  begin p = 7'h36; s = 7'h5E; end
                6'd8:  begin p = 7'h37; s = 7'h26; end
                6'd9:  begin p = 7'h38; s = 7'h2A; end
                6'd10: begin p = 7'h39; s = 7'h28; end
                6'd11: begin p = 7'h30; s = 7'h29; end
                6'd12: begin p = 7'h2D; s = 7'h5F; end
                6'd13: begin p = 7'h3D; s = 7'h2B; end
                6'd14: begin p = 7'h08; s = 7'h08; end
                6'd15: begin p = 7'h09; s = 7'h09; end
                6'd16: begin p = 7'h71; s = 7'h51; end
                6'd17: begin p = 7'h77; s = 7'h57; end
                6'd18: begin p = 7'h65; s = 7'h45; end
                6'd19: begin p = 7'h72; s = 7'h52; end
                6'd20: begin p = 7'h74; s = 7'h54; end
                6'd21: begin p = 7'h79; s = 7'h59; end
                6'd22: begin p = 7'h75; s = 7'h55; end
                6'd23: begin p = 7'h69; s = 7'h49; end
                6'd24: begin p = 7'h6F; s = 7'h4F; end
                6'd25: begin p = 7'h70; s = 7'h50; end
                6'd26: begin p = 7'h5B; s = 7'h7B; end
                6'd27: begin p = 7'h5D; s = 7'h7D; end
                6'd28: begin p = 7'h0A; s = 7'h0A; end
                6'd30: begin p = 7'h61; s = 7'h41; end
                6'd31: begin p = 7'h73; s = 7'h53; end
                6'd32: begin p = 7'h64; s = 7'h44; end
                6'd33: begin p = 7'h66; s = 7'h46; end
                6'd34: begin p = 7'h67; s = 7'h47; end
                6'd35: begin p = 7'h68; s = 7'h48; end
                6'd36: begin p = 7'h6A; s = 7'h4A; end
                6'd37: begin p = 7'h6B; s = 7'h4B; end
                6'd38: begin p = 7'h6C; s = 7'h4C; end
                6'd39: begin p = 7'h3B; s = 7'h3A; end
                6'd40: begin p = 7'h27; s = 7'h22; end
                6'd41: begin p = 7'h60; s = 7'h7E; end
                6'd43: begin p = 7'h5C; s = 7'h7C; end
                6'd44: begin p = 7'h7A; s = 7'h5A; end
                6'd45: begin p = 7'h78; s = 7'h58; end
                6'd46: begin p = 7'h63; s = 7'h43; end
                6'd47: begin p = 7'h76; s = 7'h56; end
                6'd48: begin p = 7'h62; s = 7'h42; end
                6'd49: begin p = 7'h6E; s = 7'h4E; end
                6'd50: begin p = 7'h6D; s = 7'h4D; end
                6'd51: begin p = 7'h2C; s = 7'h3C; end
                6'd52: begin p = 7'h2E; s = 7'h3E; end
                6'd53: begin p = 7'h2F; s = 7'h3F; end
                6'd55: begin p = 7'h2A; s = 7'h2A; end
                6'd57: begin p = 7'h20; s = 7'h20; end
                default: begin p = CHAR_NONE; s = CHAR_NONE; end
            endcase
            key_char = shift ? s : p;
        end
    endfunction

    // Caps lock swaps the case of letters only.
    function automatic logic [6:0] caps_flip(input logic [6:0] c);
        begin
            if ((c >= 7'h61 && c <= 7'h7A) || (c >= 7'h41 && c <= 7'h5A)) begin
                caps_flip = c ^ 7'h20;
            end else begin
                caps_flip = c;
            end
        end
    endfunction

endpackage

/* hw/rtl/scancode_to_ascii_line_input_core.sv */
// Top level of the scan code to ASCII line input core: one register stage from
// scan code to line event. Depends on scasc_pkg.
//
// Usage:
//   s_ channel: one set-1 scan code per item in s_tdata[7:0]; bit 7 marks a
//   key release.
//   m_ channel: exactly one result item per scan code. m_tlast is line_done
//   (a newline ended the line); m_tdata carries the echoed character, the
//   finished line's length and the dropped flag. The consumer stores the line
//   by collecting items with char_valid set.
//   m_tvalid rises in the cycle after acceptance. Throughput is one item per
//   cycle unless the receiver stalls: the lookup table, caps flip and position
//   compare sit between the input handshake and the single output register.
//   s_tready stays high while the output register is empty or being drained
//   in the same cycle, so a stalled receiver holds the result in place and
//   backs up the input by exactly one item; nothing is lost or repeated.
//   Reset (aresetn low, synchronous) releases shift, clears caps lock, sets
//   the line position to zero and empties the output register.
module scancode_to_ascii_line_input_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scancode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] char_valid, [7:1] char_code,
                                   // [15:8] line_length, [16] char_dropped
    output logic        m_tlast    // line_done
);

    logic                   shift_reg,    shift_next;
    logic                   caps_reg,     caps_next;
    logic [7:0]             pos_reg,      pos_next;
    logic                   out_vld_reg,  out_vld_next;
    scasc_pkg::line_event_t out_reg,      out_next;
    logic                   out_last_reg, out_last_next;

    logic       accept;
    logic       is_key;
    logic [6:0] mapped;
    logic [6:0] ch;

    // Take a new item whenever the output register is free or drains now.
    assign s_tready = !out_vld_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Modifier tracking: shift make/break and caps lock toggle.
    always_comb begin
        shift_next = shift_reg;
        caps_next  = caps_reg;
        if (accept) begin
            if (s_tdata == scasc_pkg::SC_LSHIFT_MAKE ||
                s_tdata == scasc_pkg::SC_RSHIFT_MAKE) begin
                shift_next = 1'b1;
            end else if (s_tdata == scasc_pkg::SC_LSHIFT_BREAK ||
                         s_tdata == scasc_pkg::SC_RSHIFT_BREAK) begin
                shift_next = 1'b0;
            end else if (s_tdata == scasc_pkg::SC_CAPS_MAKE) begin
                caps_next = !caps_reg;
            end
        end
    end

    // Only make codes inside the table produce a character.
    assign is_key = !s_tdata[7] && (s_tdata < scasc_pkg::KEY_TABLE_SIZE);
    assign mapped = scasc_pkg::key_char(s_tdata[5:0], shift_next);
    assign ch     = caps_reg ? scasc_pkg::caps_flip(mapped) : mapped;

    // Line logic: newline reports and clears, backspace and blank keys do nothing, full line drops, else append.
    always_comb begin
        pos_next      = pos_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        if (accept) begin
            out_vld_next  = 1'b1;
            out_next      = '0;
            out_last_next = 1'b0;
            if (is_key) begin
                if (ch == scasc_pkg::CHAR_NEWLINE) begin
                    out_last_next        = 1'b1;
                    out_next.line_length = pos_reg;
                    pos_next             = '0;
                end else if (ch == scasc_pkg::CHAR_BACKSPACE || ch == scasc_pkg::CHAR_NONE) begin
                    // ignore: no character, no position change
                end else if (pos_reg >= scasc_pkg::LINE_LIMIT) begin
                    out_next.char_dropped = 1'b1;
                end else begin
                    out_next.char_valid = 1'b1;
                    out_next.char_code  = ch;
                    pos_next            = pos_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg   <= 1'b0;
            caps_reg    <= 1'b0;
            pos_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            shift_reg   <= shift_next;
            caps_reg    <= caps_next;
            pos_reg     <= pos_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload holds its value while the receiver stalls.
    always_ff @(posedge aclk) begin
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'b0, out_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for scancode_to_ascii_line_input_core: scan code items in,
// line events out, each result checked against a cycle-free key predictor.
// Depends on scasc_pkg and the core RTL only.
`timescale 1ns / 100ps

module testbench;

    // Expected line event: the packed m_tdata fields plus line_done from m_tlast.
    typedef struct packed {
        logic                   line_done;
        scasc_pkg::line_event_t ev;
    } key_result_t;

    // One row of the directed table; pinned rows carry a hand-typed result.
    typedef struct packed {
        logic [7:0]  code;
        logic        pinned;
        key_result_t want;
    } stim_row_t;

    // Set-1 key tables, entry 0 in the top byte.
    localparam logic [58*8-1:0] PLAIN_KEYS = {
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
        8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68,
        8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
    };
    localparam logic [58*8-1:0] SHIFT_KEYS = {
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
        8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48,
        8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    localparam int RANDOM_CODES = 850;
    localparam int HOLD_CYCLES  = 120;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    // Predictor state: mirrors the keyboard flags and the line position.
    logic        shift_down  = 1'b0;
    logic        caps_active = 1'b0;
    logic [7:0]  line_pos    = 8'd0;

    key_result_t pending_events[$];
    stim_row_t   dir_rows[$];
    int          fault_count    = 0;
    int          accepted_codes = 0;
    int          tx_idle_pct    = 22;
    int          rx_idle_pct    = 73;
    logic        hold_rx        = 1'b0;

    scancode_to_ascii_line_input_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Advance the keyboard state by one scan code and return the line event it causes.
    function automatic key_result_t predict_key(input logic [7:0] code);
        key_result_t r;
        logic [6:0]  ch;
        int          idx;
        r = '0;
        if (code == scasc_pkg::SC_LSHIFT_MAKE || code == scasc_pkg::SC_RSHIFT_MAKE) begin
            shift_down = 1'b1;
        end else if (code == scasc_pkg::SC_LSHIFT_BREAK ||
                     code == scasc_pkg::SC_RSHIFT_BREAK) begin
            shift_down = 1'b0;
        end else if (code == scasc_pkg::SC_CAPS_MAKE) begin
            caps_active = ~caps_active;
        end
        // Releases and codes past the table carry no character.
        if (code[7] || code >= scasc_pkg::KEY_TABLE_SIZE) begin
            return r;
        end
        idx = int'(code);
        ch = shift_down ? SHIFT_KEYS[(57 - idx) * 8 +: 7] : PLAIN_KEYS[(57 - idx) * 8 +: 7];
        // Caps lock swaps case on letters only, so shift plus caps keeps < > ?.
        if (caps_active && ((ch >= 7'h61 && ch <= 7'h7A) || (ch >= 7'h41 && ch <= 7'h5A))) begin
            ch = ch ^ 7'h20;
        end
        if (ch == scasc_pkg::CHAR_NEWLINE) begin
            r.line_done      = 1'b1;
            r.ev.line_length = line_pos;
            line_pos         = 8'd0;
        end else if (ch == scasc_pkg::CHAR_BACKSPACE || ch == scasc_pkg::CHAR_NONE) begin
            // backspace and empty keys leave the line alone
        end else if (line_pos >= scasc_pkg::LINE_LIMIT) begin
            r.ev.char_dropped = 1'b1;
        end else begin
            r.ev.char_valid = 1'b1;
            r.ev.char_code  = ch;
            line_pos        = line_pos + 8'd1;
        end
        return r;
    endfunction

    function automatic stim_row_t mk_row(input logic [7:0] code, input logic pinned,
                                         input logic valid, input logic [6:0] ch,
                                         input logic done, input logic [7:0] len,
                                         input logic drop);
        stim_row_t row;
        row.code                 = code;
        row.pinned               = pinned;
        row.want.line_done       = done;
        row.want.ev.char_valid   = valid;
        row.want.ev.char_code    = ch;
        row.want.ev.line_length  = len;
        row.want.ev.char_dropped = drop;
        return row;
    endfunction

    // Offer one scan code item after a random gap; on acceptance queue its result.
    task automatic send_code(input logic [7:0] code, input logic pinned,
                             input key_result_t fixed);
        key_result_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_key(code);
        pending_events.push_back(pinned ? fixed : predicted);
        accepted_codes++;
    endtask

    // Drop valid and hold the sender until every queued result has come out.
    task automatic drain_events();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
    endtask

    // One typed line: mostly printable make codes, salted with modifiers, caps,
    // releases and raw noise, closed by Enter.
    task automatic send_random_line(input int len, inout int sent);
        logic [7:0] code;
        int         roll;
        for (int i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                code = 8'($urandom_range(0, 255));
            end else if (roll < 14) begin
                case ($urandom_range(0, 3))
                    0: code = scasc_pkg::SC_LSHIFT_MAKE;
                    1: code = scasc_pkg::SC_RSHIFT_MAKE;
                    2: code = scasc_pkg::SC_LSHIFT_BREAK;
                    default: code = scasc_pkg::SC_RSHIFT_BREAK;
                endcase
            end else if (roll < 17) begin
                code = scasc_pkg::SC_CAPS_MAKE;
            end else if (roll < 22) begin
                code = 8'h80 | 8'($urandom_range(0, 57));
            end else begin
                code = 8'($urandom_range(1, 57));
                if (code == 8'h1C) code = 8'h1E;
            end
            send_code(code, 1'b0, '0);
            sent++;
        end
        send_code(8'h1C, 1'b0, '0);
        sent++;
    endtask

    // Result side: check each accepted item, then pick the next ready level.
    always @(posedge aclk) begin
        key_result_t got;
        key_result_t want;
        if (m_tvalid && m_tready) begin
            got = {m_tlast, m_tdata[16:0]};
            if (pending_events.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected line event %h", $time, got);
            end else begin
                want = pending_events.pop_front();
                if (got.ev.char_valid !== want.ev.char_valid ||
                    got.ev.char_code !== want.ev.char_code ||
                    got.line_done !== want.line_done ||
                    got.ev.line_length !== want.ev.line_length ||
                    got.ev.char_dropped !== want.ev.char_dropped) begin
                    fault_count++;
                    $display("%0t: expected valid=%b char=%h done=%b len=%0d drop=%b",
                             $time, want.ev.char_valid, want.ev.char_code, want.line_done,
                             want.ev.line_length, want.ev.char_dropped);
                    $display("%0t:   actual valid=%b char=%h done=%b len=%0d drop=%b",
                             $time, got.ev.char_valid, got.ev.char_code, got.line_done,
                             got.ev.line_length, got.ev.char_dropped);
                end
            end
        end
        if (hold_rx) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Long receiver hold-off mid-run: the output register fills and s_tready drops
    // while the sender keeps offering items.
    initial begin
        wait (accepted_codes >= 400);
        @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    initial begin
        int sent;
        int line_no;
        int phase;
        int len;

        // Directed table: extremes, every special key and the caps/shift combinations.
        dir_rows.push_back(mk_row(8'h1E, 1'b1, 1'b1, 7'h61, 1'b0, 8'd0, 1'b0));  // 'a' after reset
        dir_rows.push_back(mk_row(8'h00, 1'b1, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));  // empty entry
        dir_rows.push_back(mk_row(8'hFF, 1'b1, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));  // top release
        dir_rows.push_back(mk_row(8'h80, 1'b1, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));  // low release
        dir_rows.push_back(mk_row(8'h7F, 1'b1, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));  // past table
        dir_rows.push_back(mk_row(8'h3B, 1'b1, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));  // past table
        dir_rows.push_back(mk_row(8'h0E, 1'b1, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));  // backspace
        dir_rows.push_back(mk_row(8'h01, 1'b1, 1'b1, 7'h1B, 1'b0, 8'd0, 1'b0));  // escape
        dir_rows.push_back(mk_row(8'h0F, 1'b1, 1'b1, 7'h09, 1'b0, 8'd0, 1'b0));  // tab
        dir_rows.push_back(mk_row(8'h1D, 1'b1, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));  // control key
        dir_rows.push_back(mk_row(scasc_pkg::SC_CAPS_MAKE, 1'b1, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));
        dir_rows.push_back(mk_row(8'h10, 1'b0, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));  // caps letter
        dir_rows.push_back(mk_row(8'h33, 1'b0, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));  // comma stays
        dir_rows.push_back(mk_row(scasc_pkg::SC_LSHIFT_MAKE, 1'b1, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));
        dir_rows.push_back(mk_row(8'h33, 1'b0, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));  // shift+caps '<'
        dir_rows.push_back(mk_row(8'h10, 1'b0, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));  // shift+caps 'q'
        dir_rows.push_back(mk_row(8'h02, 1'b0, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));
        dir_rows.push_back(mk_row(scasc_pkg::SC_LSHIFT_BREAK, 1'b1, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));
        dir_rows.push_back(mk_row(scasc_pkg::SC_RSHIFT_MAKE, 1'b1, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));
        dir_rows.push_back(mk_row(8'h35, 1'b0, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));
        dir_rows.push_back(mk_row(scasc_pkg::SC_RSHIFT_BREAK, 1'b1, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));
        dir_rows.push_back(mk_row(scasc_pkg::SC_CAPS_MAKE, 1'b1, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));
        dir_rows.push_back(mk_row(8'h39, 1'b0, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));  // space
        dir_rows.push_back(mk_row(8'h1C, 1'b0, 1'b0, 7'h00, 1'b0, 8'd0, 1'b0));  // newline
        dir_rows.push_back(mk_row(8'h1C, 1'b1, 1'b0, 7'h00, 1'b1, 8'd0, 1'b0));  // empty line

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            send_code(dir_rows[i].code, dir_rows[i].pinned, dir_rows[i].want);
        end
        drain_events();

        // Random lines; line 2 runs well past the line capacity to force drops.
        sent    = 0;
        line_no = 0;
        phase   = 0;
        while (sent < RANDOM_CODES) begin
            len = (line_no == 2) ? $urandom_range(380, 420) : $urandom_range(0, 30);
            send_random_line(len, sent);
            line_no++;
            if (phase == 0 && sent >= RANDOM_CODES / 3) begin
                drain_events();
                tx_idle_pct = 73;
                rx_idle_pct <= 22;
                phase = 1;
            end else if (phase == 1 && sent >= 2 * RANDOM_CODES / 3) begin
                drain_events();
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
                phase = 2;
            end
        end

        // Let the last results out, then keep watching for strays.
        drain_events();
        repeat (10) @(posedge aclk);
        if (fault_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
